/* rtl/button_debounce_hold_edge_core_assert.svh */
// Assertion macros used by button_debounce_hold_edge_core.sv.
`ifndef BUTTON_DEBOUNCE_HOLD_EDGE_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_EDGE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDHE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define BDHE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/bdhe_pkg.sv */
`default_nettype none

package bdhe_pkg;

   localparam int BUTTON_COUNT = 8;
   localparam int BTN_IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam logic [7:0] BUTTON_LIMIT = 8'(BUTTON_COUNT);

   localparam logic [15:0] DEBOUNCE_TIME_RESET = 16'd50;
   localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;
   localparam logic [15:0] EDGE_WINDOW_RESET = 16'd40;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_RISE   = 2'd2,
      KIND_FALL   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_RELEASED = 2'd0,
      MODE_PRESSED  = 2'd1,
      MODE_HELD     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE_TIME = 2'd0,
      CSR_HOLD_TIME     = 2'd1,
      CSR_EDGE_WINDOW   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] hold_time;
      logic [15:0] edge_window;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] debounce_stamp;
      logic [31:0] hold_stamp;
      logic [31:0] rise_stamp;
      logic [31:0] fall_stamp;
   } btn_state_type;

   typedef struct packed {
      logic is_released;
      logic is_pressed;
      logic is_held;
      logic edge_seen;
   } flags_type;

   localparam btn_state_type BTN_STATE_RESET = '{MODE_RELEASED, 32'd0, 32'd0, 32'd0, 32'd0};

endpackage

`default_nettype wire

/* rtl/bdhe_update.sv */
`default_nettype none

module bdhe_update
   import bdhe_pkg::*;
(
   input  btn_state_type state_cur,
   input  kind_type      kind,
   input  logic          pin_high,
   input  logic [31:0]   now_ms,
   input  cfg_type       cfg,
   output btn_state_type state_in,
   output flags_type     flags_in
);

   logic [31:0] since_debounce;
   logic [31:0] since_hold;
   logic [31:0] edge_stamp;
   logic [31:0] since_edge;
   logic        debounce_zero;
   logic        debounce_done;
   logic        hold_done;
   logic        edge_in_window;
   logic        edge_seen;

   assign since_debounce = now_ms - state_cur.debounce_stamp;
   assign since_hold     = now_ms - state_cur.hold_stamp;
   assign edge_stamp     = (kind == KIND_FALL) ? state_cur.fall_stamp : state_cur.rise_stamp;
   assign since_edge     = now_ms - edge_stamp;
   assign debounce_zero  = (cfg.debounce_time == 16'd0);
   assign debounce_done  = (since_debounce >= 32'(cfg.debounce_time));
   assign hold_done      = (since_hold >= 32'(cfg.hold_time));
   assign edge_in_window = (since_edge < 32'(cfg.edge_window))
                           && (now_ms > 32'(cfg.edge_window));

   // A sample that restarts the debounce stamp passes only with a zero debounce time.
   always_comb begin
      state_in  = state_cur;
      edge_seen = 1'b0;
      case (kind)
         KIND_SAMPLE: begin
            case (state_cur.mode) inside
               MODE_PRESSED, MODE_HELD: begin
                  if (!pin_high) begin
                     state_in.debounce_stamp = now_ms;
                     if (state_cur.mode == MODE_PRESSED && hold_done) begin
                        state_in.mode = MODE_HELD;
                     end
                  end
                  if (pin_high ? debounce_done : debounce_zero) begin
                     state_in.fall_stamp = now_ms;
                     state_in.mode       = MODE_RELEASED;
                  end
               end
               default: begin
                  if (pin_high) begin
                     state_in.debounce_stamp = now_ms;
                  end
                  if (pin_high ? debounce_zero : debounce_done) begin
                     state_in.rise_stamp = now_ms;
                     state_in.hold_stamp = now_ms;
                     state_in.mode       = MODE_PRESSED;
                  end
               end
            endcase
         end
         KIND_RISE: begin
            edge_seen           = edge_in_window;
            state_in.rise_stamp = 32'd0;
         end
         KIND_FALL: begin
            edge_seen           = edge_in_window;
            state_in.fall_stamp = 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      flags_in.is_pressed  = (state_in.mode == MODE_PRESSED) || (state_in.mode == MODE_HELD);
      flags_in.is_released = !flags_in.is_pressed;
      flags_in.is_held     = (state_in.mode == MODE_HELD);
      flags_in.edge_seen   = edge_seen;
   end

endmodule

`default_nettype wire

/* rtl/button_debounce_hold_edge_core.sv */
// Channel  Ports                                      Handshake
// req      req_kind, req_button, req_pin_high,        req_valid / req_ready
//          req_now_ms
// rsp      rsp_is_released, rsp_is_pressed,           rsp_valid / rsp_ready
//          rsp_is_held, rsp_edge_seen
// csr      csr_index, csr_write_data                  csr_write_enable
//
// A word is taken each cycle unless both registers are full and rsp_ready is low.
// The per-button state is read, updated and written back between the input register
// and the result register, so consecutive words on the same button see each other.
// Synchronous reset clears all button states and loads the default timings.
// A stalled result holds its register; an empty input register still takes one word.

`default_nettype none
`include "button_debounce_hold_edge_core_assert.svh"

module button_debounce_hold_edge_core
   import bdhe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_button,
   input  logic        req_pin_high,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_released,
   output logic        rsp_is_pressed,
   output logic        rsp_is_held,
   output logic        rsp_edge_seen,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type        cfg_ff;
   btn_state_type  state_ff [BUTTON_COUNT];

   logic           in_valid_ff;
   kind_type       kind_ff;
   logic [7:0]     button_ff;
   logic           pin_high_ff;
   logic [31:0]    now_ms_ff;

   logic           rsp_valid_ff;
   flags_type      rsp_flags_ff;

   logic                 advance;
   logic                 in_range;
   logic [BTN_IDX_W-1:0] btn_idx;
   btn_state_type        state_cur;
   btn_state_type        state_in;
   flags_type            flags_in;
   flags_type            rsp_flags_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign in_range  = (button_ff < BUTTON_LIMIT);
   assign btn_idx   = button_ff[BTN_IDX_W-1:0];
   assign state_cur = in_range ? state_ff[btn_idx] : BTN_STATE_RESET;

   bdhe_update u_update (
      .state_cur (state_cur),
      .kind      (kind_ff),
      .pin_high  (pin_high_ff),
      .now_ms    (now_ms_ff),
      .cfg       (cfg_ff),
      .state_in  (state_in),
      .flags_in  (flags_in)
   );

   assign rsp_flags_in = in_range ? flags_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= DEBOUNCE_TIME_RESET;
         cfg_ff.hold_time     <= HOLD_TIME_RESET;
         cfg_ff.edge_window   <= EDGE_WINDOW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME: cfg_ff.debounce_time <= csr_write_data;
            CSR_HOLD_TIME:     cfg_ff.hold_time     <= csr_write_data;
            CSR_EDGE_WINDOW:   cfg_ff.edge_window   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            state_ff[i] <= BTN_STATE_RESET;
         end
      end else if (in_valid_ff && advance && in_range) begin
         state_ff[btn_idx] <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         kind_ff     <= kind_type'(req_kind);
         button_ff   <= req_button;
         pin_high_ff <= req_pin_high;
         now_ms_ff   <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_released = rsp_flags_ff.is_released;
   assign rsp_is_pressed  = rsp_flags_ff.is_pressed;
   assign rsp_is_held     = rsp_flags_ff.is_held;
   assign rsp_edge_seen   = rsp_flags_ff.edge_seen;

   `BDHE_ASSERT_NEXT(a_word_reaches_result, in_valid_ff && advance, rsp_valid_ff)
   `BDHE_ASSERT_NEXT(a_stalled_input_holds, in_valid_ff && !advance,
                     in_valid_ff && $stable(now_ms_ff) && $stable(button_ff))
   `BDHE_ASSERT_SAME(a_held_is_pressed, rsp_valid_ff && rsp_flags_ff.is_held,
                     rsp_flags_ff.is_pressed)
   `BDHE_ASSERT_SAME(a_flags_exclusive,
                     rsp_valid_ff && (rsp_flags_ff.is_released || rsp_flags_ff.is_pressed),
                     rsp_flags_ff.is_released != rsp_flags_ff.is_pressed)

endmodule

`default_nettype wire
